[sv/rgbhsv_pkg.sv]
// shared types and constants for the rgb to hsv converter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

  // pixel in and result out, one transfer each
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  // scaling constants
  localparam logic [7:0] SAT_FULL       = 8'd255;
  localparam logic [7:0] HUE_STEP       = 8'd43;
  localparam logic [7:0] HUE_BASE_RED   = 8'd0;
  localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;

  // divider shape: one quotient bit per stage, quotients always below 256
  localparam int DIV_STAGES = 8;
  localparam int NUM_W      = 16;

  // per-item data that rides alongside the dividers
  typedef struct packed {
    logic [7:0] base;
    logic       neg;
    logic       zero;
    logic [7:0] brightness;
  } side_t;

endpackage

`default_nettype wire

[sv/rgb_to_hsv_converter.sv]
// rgb to hsv converter: 8-bit pixel in, 8-bit hue, saturation, value out
// stages: input, sort, multiply, divider stages, output; one pixel per cycle unless hsv_ready stalls the output
// the two dividers resolve one quotient bit per stage, eight stages each
// reset clears every stage valid bit; data registers are not reset
// depends on rgbhsv_pkg and rgbhsv_div_pipe
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_converter import rgbhsv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   hsv_valid,
  input  logic   hsv_ready,
  output hsv_t   hsv
);

  localparam int ST_IN   = 0;
  localparam int ST_SORT = 1;
  localparam int ST_MUL  = 2;
  localparam int ST_DIV0 = 3;
  localparam int ST_OUT  = ST_DIV0 + DIV_STAGES;
  localparam int NSTG    = ST_OUT + 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_next;
  logic [NSTG:0]   load;

  // stage load chain: a stage takes new data when empty or draining
  always_comb begin
    load[NSTG] = hsv_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  always_comb begin
    vld_next = vld;
    if (load[0]) begin
      vld_next[0] = pixel_valid;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (load[k]) begin
        vld_next[k] = vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign pixel_ready = load[ST_IN];

  // input register
  pixel_t pix0;

  always_ff @(posedge clk) begin
    if (load[ST_IN]) begin
      pix0 <= pixel;
    end
  end

  // max, min, sector and channel difference
  logic [7:0] hi_c, lo_c, base_c, opa_c, opb_c;
  logic       neg_c;

  always_comb begin
    if (pix0.red >= pix0.green && pix0.red >= pix0.blue) begin
      hi_c   = pix0.red;
      base_c = HUE_BASE_RED;
      opa_c  = pix0.green;
      opb_c  = pix0.blue;
    end else if (pix0.green >= pix0.blue) begin
      hi_c   = pix0.green;
      base_c = HUE_BASE_GREEN;
      opa_c  = pix0.blue;
      opb_c  = pix0.red;
    end else begin
      hi_c   = pix0.blue;
      base_c = HUE_BASE_BLUE;
      opa_c  = pix0.red;
      opb_c  = pix0.green;
    end
    lo_c = pix0.red;
    if (pix0.green < lo_c) begin
      lo_c = pix0.green;
    end
    if (pix0.blue < lo_c) begin
      lo_c = pix0.blue;
    end
    neg_c = (opa_c < opb_c);
  end

  logic [7:0] hi1, span1, base1, absd1;
  logic       neg1;

  always_ff @(posedge clk) begin
    if (load[ST_SORT]) begin
      hi1   <= hi_c;
      span1 <= hi_c - lo_c;
      base1 <= base_c;
      neg1  <= neg_c;
      absd1 <= neg_c ? (opb_c - opa_c) : (opa_c - opb_c);
    end
  end

  // scale numerators by the constant factors
  logic [NUM_W-1:0] num_s2, num_h2;
  logic [7:0]       hi2, span2;
  side_t            side2;

  always_ff @(posedge clk) begin
    if (load[ST_MUL]) begin
      num_s2           <= NUM_W'(span1) * NUM_W'(SAT_FULL);
      num_h2           <= NUM_W'(absd1) * NUM_W'(HUE_STEP);
      hi2              <= hi1;
      span2            <= span1;
      side2.base       <= base1;
      side2.neg        <= neg1;
      side2.zero       <= (span1 == 8'd0);
      side2.brightness <= hi1;
    end
  end

  // saturation and hue offset dividers
  logic [DIV_STAGES-1:0] div_en;
  logic [DIV_STAGES-1:0] quo_s, quo_h;

  assign div_en = load[ST_OUT-1:ST_DIV0];

  rgbhsv_div_pipe u_div_sat (
    .clk (clk),
    .en  (div_en),
    .num (num_s2),
    .den (hi2),
    .quo (quo_s)
  );

  rgbhsv_div_pipe u_div_hue (
    .clk (clk),
    .en  (div_en),
    .num (num_h2),
    .den (span2),
    .quo (quo_h)
  );

  // sector, flags and brightness travel beside the dividers
  side_t side [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (div_en[0]) begin
      side[0] <= side2;
    end
    for (int j = 1; j < DIV_STAGES; j++) begin
      if (div_en[j]) begin
        side[j] <= side[j-1];
      end
    end
  end

  // hue assembly, wraps modulo 256
  side_t      side_last;
  logic [7:0] hue_c;

  assign side_last = side[DIV_STAGES-1];
  assign hue_c = side_last.neg ? (side_last.base - quo_h[7:0])
                               : (side_last.base + quo_h[7:0]);

  always_ff @(posedge clk) begin
    if (load[ST_OUT]) begin
      hsv.hue        <= side_last.zero ? 8'd0 : hue_c;
      hsv.saturation <= side_last.zero ? 8'd0 : quo_s[7:0];
      hsv.brightness <= side_last.brightness;
    end
  end

  assign hsv_valid = vld[ST_OUT];

  // checks
  a_black_pixel: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.brightness == 8'd0 |-> hsv.hue == 8'd0 && hsv.saturation == 8'd0)
    else $error("black pixel with nonzero hue or saturation");

  a_grey_pixel: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.saturation == 8'd0 |-> hsv.hue == 8'd0)
    else $error("grey pixel with nonzero hue");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    hsv_ready |-> pixel_ready)
    else $error("input stalled while the output drains");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !hsv_ready && pixel_valid && pixel_ready |=> hsv_valid)
    else $error("result lost during an output stall");

endmodule

`default_nettype wire

[sv/rgbhsv_div_pipe.sv]
// pipelined restoring divider, one quotient bit resolved per stage
// depends on rgbhsv_pkg; stage load enables come from the top level
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_div_pipe import rgbhsv_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NUM_W-1:0]      num,
  input  logic [7:0]            den,
  output logic [DIV_STAGES-1:0] quo
);

  logic [NUM_W-1:0]      rem  [DIV_STAGES];
  logic [7:0]            dsr  [DIV_STAGES];
  logic [DIV_STAGES-1:0] qbit [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - i;

    logic [NUM_W-1:0]      rem_prev;
    logic [7:0]            dsr_prev;
    logic [DIV_STAGES-1:0] q_prev;
    logic [NUM_W-1:0]      trial;
    logic                  fits;

    // previous stage, or the operands for the first one
    if (i == 0) begin : g_first
      assign rem_prev = num;
      assign dsr_prev = den;
      assign q_prev   = '0;
    end else begin : g_rest
      assign rem_prev = rem[i-1];
      assign dsr_prev = dsr[i-1];
      assign q_prev   = qbit[i-1];
    end

    // trial subtract of the shifted divisor
    assign trial = NUM_W'(dsr_prev) << K;
    assign fits  = (rem_prev >= trial);

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem[i]  <= fits ? (rem_prev - trial) : rem_prev;
        dsr[i]  <= dsr_prev;
        qbit[i] <= fits ? (q_prev | (DIV_STAGES'(1) << K)) : q_prev;
      end
    end
  end

  assign quo = qbit[DIV_STAGES-1];

endmodule

`default_nettype wire
